FILE: design/dst_pkg.sv
// Shared types, constants and functions for the DST stitch stream decoder.
// Used by dst_rec_dec and dst_stitch_stream_decoder; depends on nothing else.
package dst_pkg;

  // Geometry of the file: header length and width of the position fields.
  localparam int unsigned HEADER_BYTES = 512;
  localparam int unsigned POS_WIDTH    = 24;
  localparam int unsigned LAYER_WIDTH  = 16;
  localparam int unsigned MAGIC_LEN    = 3;

  // The byte counter saturates at the end of the first record.
  localparam int unsigned FIRST_REC_END = HEADER_BYTES + 3;
  localparam int unsigned CNT_WIDTH     = $clog2(FIRST_REC_END + 1);

  // A record moves at most 121 steps per axis, which fits in 8 signed bits.
  localparam int unsigned DELTA_WIDTH = 8;

  // Flag masks tested on the third record byte, in priority order.
  localparam logic [7:0] MASK_END    = 8'hF3;
  localparam logic [7:0] MASK_COLOR  = 8'hC3;
  localparam logic [7:0] MASK_JUMP   = 8'h83;
  localparam logic [7:0] MASK_STITCH = 8'h03;

  // Expected first bytes of the file: "LA:".
  localparam logic [7:0] MAGIC [MAGIC_LEN] = '{8'h4C, 8'h41, 8'h3A};

  typedef enum logic [3:0] {
    KIND_STITCH     = 4'd0,
    KIND_START      = 4'd1,
    KIND_JUMP       = 4'd2,
    KIND_COLOR      = 4'd3,
    KIND_END        = 4'd4,
    KIND_BAD_END    = 4'd5,
    KIND_UNKNOWN    = 4'd6,
    KIND_BAD_HEADER = 4'd7,
    KIND_TOO_SHORT  = 4'd8
  } kind_e;

  // Stream mode, one-hot.
  typedef enum logic [2:0] {
    MODE_HEADER  = 3'b001,
    MODE_RECORDS = 3'b010,
    MODE_DONE    = 3'b100
  } mode_e;

  // Decoded view of one complete record.
  typedef struct packed {
    kind_e                          kind;
    logic signed [DELTA_WIDTH-1:0]  dx;
    logic signed [DELTA_WIDTH-1:0]  dy;
  } rec_t;

  // One balanced-ternary digit: +w when pos is set, -w when neg is set.
  function automatic logic signed [DELTA_WIDTH-1:0] trit(
    input logic pos,
    input logic neg,
    input logic signed [DELTA_WIDTH-1:0] w
  );
    logic signed [DELTA_WIDTH-1:0] r;
    r = '0;
    if (pos) r = r + w;
    if (neg) r = r - w;
    return r;
  endfunction

endpackage

FILE: design/dst_rec_dec.sv
// Combinational decoder for one 3-byte DST record: deltas and record kind.
// Depends on dst_pkg for the record struct, kinds, masks and trit().
module dst_rec_dec import dst_pkg::*; (
  input  logic [7:0] b0_i,
  input  logic [7:0] b1_i,
  input  logic [7:0] b2_i,
  input  logic       stroke_pending_i,
  output rec_t       rec_o
);

  // Sum the ternary digits of each axis, then classify the record; the first
  // matching flag pattern wins.
  always_comb begin
    rec_o.dx = trit(b0_i[0], b0_i[1], 8'sd1)  + trit(b0_i[2], b0_i[3], 8'sd9)
             + trit(b1_i[0], b1_i[1], 8'sd3)  + trit(b1_i[2], b1_i[3], 8'sd27)
             + trit(b2_i[2], b2_i[3], 8'sd81);
    rec_o.dy = trit(b0_i[7], b0_i[6], 8'sd1)  + trit(b0_i[5], b0_i[4], 8'sd9)
             + trit(b1_i[7], b1_i[6], 8'sd3)  + trit(b1_i[5], b1_i[4], 8'sd27)
             + trit(b2_i[5], b2_i[4], 8'sd81);

    priority if ((b2_i & MASK_END) == MASK_END) begin
      rec_o.kind = (b0_i == 8'h00 && b1_i == 8'h00) ? KIND_END : KIND_BAD_END;
    end else if ((b2_i & MASK_COLOR) == MASK_COLOR) begin
      rec_o.kind = KIND_COLOR;
    end else if ((b2_i & MASK_JUMP) == MASK_JUMP) begin
      rec_o.kind = KIND_JUMP;
    end else if ((b2_i & MASK_STITCH) == MASK_STITCH) begin
      rec_o.kind = stroke_pending_i ? KIND_START : KIND_STITCH;
    end else begin
      rec_o.kind = KIND_UNKNOWN;
    end
  end

endmodule

FILE: design/dst_stitch_stream_decoder.sv
// Top level of the DST stitch stream decoder: stream state and result register.
// Depends on dst_pkg and on dst_rec_dec for record decoding.
//
// Usage: the file is fed one byte per request on the input channel
// (file_byte_i, last_byte_i, in_valid_i / in_stall_o). last_byte_i marks the
// final byte of a file; after that byte the stream state returns to its
// reset values and the next request starts a new file.
// Every complete 3-byte record after the header, until decoding ends, gives
// one result request on the output channel (kind_o, pos_x_o, pos_y_o,
// layer_o, out_valid_o / out_stall_i). A bad header or a file that ends too
// early gives one error request instead.
// Throughput is one byte per cycle while the input is not stalled. The whole
// update of a byte is done in the accepting cycle, and its result sits in the
// output register from the next cycle on.
// When the receiver stalls, the result register holds its request and the
// input channel stalls only while that register is full and stalled; a byte
// arriving in the cycle the result is taken is accepted.
// Reset clears the stream state, sets start_layer to 0 and empties the
// result register. start_layer is written through cfg_we_i / cfg_wdata_i;
// the user is to write it between files, which the block does not enforce. A
// write also loads the current layer when no byte of the file has arrived yet.
module dst_stitch_stream_decoder import dst_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [LAYER_WIDTH-1:0]        cfg_wdata_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    file_byte_i,
  input  logic                          last_byte_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [3:0]                    kind_o,
  output logic signed [POS_WIDTH-1:0]   pos_x_o,
  output logic signed [POS_WIDTH-1:0]   pos_y_o,
  output logic [LAYER_WIDTH-1:0]        layer_o
);

  localparam logic [CNT_WIDTH-1:0] CntFirstRecEnd = CNT_WIDTH'(FIRST_REC_END);
  localparam logic [CNT_WIDTH-1:0] CntHeader      = CNT_WIDTH'(HEADER_BYTES);
  localparam logic [CNT_WIDTH-1:0] CntMagic       = CNT_WIDTH'(MAGIC_LEN);
  localparam logic signed [POS_WIDTH-1:0] PosMax  = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] PosMin  = {1'b1, {(POS_WIDTH-1){1'b0}}};

  // Stream state.
  logic [LAYER_WIDTH-1:0]       start_layer_q;
  logic [CNT_WIDTH-1:0]         cnt_q, cnt_d;
  logic [7:0]                   rec_b0_q, rec_b0_d;
  logic [7:0]                   rec_b1_q, rec_b1_d;
  logic [1:0]                   phase_q, phase_d;
  logic                         hdr_bad_q, hdr_bad_d;
  logic signed [POS_WIDTH-1:0]  acc_x_q, acc_x_d;
  logic signed [POS_WIDTH-1:0]  acc_y_q, acc_y_d;
  logic [LAYER_WIDTH-1:0]       layer_q, layer_d;
  logic                         stroke_q, stroke_d;
  mode_e                        mode_q, mode_d;

  // Result register.
  logic                         out_valid_q;
  kind_e                        out_kind_q;
  logic signed [POS_WIDTH-1:0]  out_x_q;
  logic signed [POS_WIDTH-1:0]  out_y_q;
  logic [LAYER_WIDTH-1:0]       out_layer_q;

  logic                         in_accept;
  logic                         emit;
  kind_e                        emit_kind;
  rec_t                         rec;
  logic signed [POS_WIDTH:0]    sum_x, sum_y;
  logic signed [POS_WIDTH-1:0]  sat_x, sat_y;

  // The input stalls only while a finished result waits and is stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Decode the record formed by the two stored bytes and the incoming one.
  dst_rec_dec u_rec_dec (
    .b0_i             (rec_b0_q),
    .b1_i             (rec_b1_q),
    .b2_i             (file_byte_i),
    .stroke_pending_i (stroke_q),
    .rec_o            (rec)
  );

  // Saturating position update.
  always_comb begin
    sum_x = {acc_x_q[POS_WIDTH-1], acc_x_q}
          + {{(POS_WIDTH+1-DELTA_WIDTH){rec.dx[DELTA_WIDTH-1]}}, rec.dx};
    sum_y = {acc_y_q[POS_WIDTH-1], acc_y_q}
          + {{(POS_WIDTH+1-DELTA_WIDTH){rec.dy[DELTA_WIDTH-1]}}, rec.dy};
    if (sum_x[POS_WIDTH] != sum_x[POS_WIDTH-1]) begin
      sat_x = sum_x[POS_WIDTH] ? PosMin : PosMax;
    end else begin
      sat_x = sum_x[POS_WIDTH-1:0];
    end
    if (sum_y[POS_WIDTH] != sum_y[POS_WIDTH-1]) begin
      sat_y = sum_y[POS_WIDTH] ? PosMin : PosMax;
    end else begin
      sat_y = sum_y[POS_WIDTH-1:0];
    end
  end

  // Next stream state and result for the byte being accepted.
  always_comb begin
    cnt_d     = cnt_q;
    rec_b0_d  = rec_b0_q;
    rec_b1_d  = rec_b1_q;
    phase_d   = phase_q;
    hdr_bad_d = hdr_bad_q;
    acc_x_d   = acc_x_q;
    acc_y_d   = acc_y_q;
    layer_d   = layer_q;
    stroke_d  = stroke_q;
    mode_d    = mode_q;
    emit      = 1'b0;
    emit_kind = KIND_UNKNOWN;

    unique case (mode_q)
      MODE_HEADER: begin
        if (cnt_q < CntMagic && file_byte_i != MAGIC[cnt_q[1:0]]) begin
          hdr_bad_d = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_d >= CntHeader) begin
          mode_d = MODE_RECORDS;
        end
      end
      MODE_RECORDS: begin
        if (cnt_q < CntFirstRecEnd) begin
          cnt_d = cnt_q + 1'b1;
        end
        unique case (phase_q)
          2'd0: begin
            rec_b0_d = file_byte_i;
            phase_d  = 2'd1;
          end
          2'd1: begin
            rec_b1_d = file_byte_i;
            phase_d  = 2'd2;
          end
          default: begin
            phase_d = 2'd0;
            emit    = 1'b1;
            if (hdr_bad_q) begin
              mode_d    = MODE_DONE;
              emit_kind = KIND_BAD_HEADER;
            end else begin
              acc_x_d   = sat_x;
              acc_y_d   = sat_y;
              emit_kind = rec.kind;
              unique case (rec.kind)
                KIND_END, KIND_BAD_END: mode_d   = MODE_DONE;
                KIND_COLOR:             layer_d  = layer_q + 1'b1;
                KIND_JUMP:              stroke_d = 1'b1;
                KIND_START:             stroke_d = 1'b0;
                default: ;
              endcase
            end
          end
        endcase
      end
      default: ;
    endcase

    // A file that ends before its first record is complete.
    if (last_byte_i && !emit && cnt_d < CntFirstRecEnd) begin
      emit      = 1'b1;
      emit_kind = KIND_TOO_SHORT;
    end
  end

  // Stream state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_layer_q <= '0;
      cnt_q         <= '0;
      rec_b0_q      <= '0;
      rec_b1_q      <= '0;
      phase_q       <= '0;
      hdr_bad_q     <= 1'b0;
      acc_x_q       <= '0;
      acc_y_q       <= '0;
      layer_q       <= '0;
      stroke_q      <= 1'b1;
      mode_q        <= MODE_HEADER;
    end else if (in_accept) begin
      if (last_byte_i) begin
        cnt_q     <= '0;
        rec_b0_q  <= '0;
        rec_b1_q  <= '0;
        phase_q   <= '0;
        hdr_bad_q <= 1'b0;
        acc_x_q   <= '0;
        acc_y_q   <= '0;
        layer_q   <= start_layer_q;
        stroke_q  <= 1'b1;
        mode_q    <= MODE_HEADER;
      end else begin
        cnt_q     <= cnt_d;
        rec_b0_q  <= rec_b0_d;
        rec_b1_q  <= rec_b1_d;
        phase_q   <= phase_d;
        hdr_bad_q <= hdr_bad_d;
        acc_x_q   <= acc_x_d;
        acc_y_q   <= acc_y_d;
        layer_q   <= layer_d;
        stroke_q  <= stroke_d;
        mode_q    <= mode_d;
      end
    end else if (cfg_we_i) begin
      start_layer_q <= cfg_wdata_i;
      if (cnt_q == '0 && mode_q == MODE_HEADER) begin
        layer_q <= cfg_wdata_i;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with the state after the byte.
  always_ff @(posedge clk_i) begin
    if (in_accept && emit) begin
      out_kind_q  <= emit_kind;
      out_x_q     <= acc_x_d;
      out_y_q     <= acc_y_d;
      out_layer_q <= layer_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign pos_x_o     = out_x_q;
  assign pos_y_o     = out_y_q;
  assign layer_o     = out_layer_q;

  // Record assembly only runs once the header has been skipped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_HEADER |-> phase_q == 2'd0 && cnt_q < CntHeader)
    else $error("record phase advanced or count overran inside the header");

  // The byte counter never passes the end of the first record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFirstRecEnd && phase_q != 2'd3)
    else $error("byte counter or record phase out of range");

  // Decoding ends only after the first record has completed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_DONE |-> cnt_q == CntFirstRecEnd)
    else $error("decoding ended before the first record");

  // A stroke-starting stitch clears the pending stroke for the next stitch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && emit && emit_kind == KIND_START && !last_byte_i |=> !stroke_q)
    else $error("stroke start not cleared after a starting stitch");

  // A new result is only loaded when the result register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && emit |=> out_valid_q)
    else $error("emitted result was lost");

endmodule

FILE: tb/dst_stitch_stream_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dst_stitch_stream_decoder: streams DST files byte by byte
// and compares every result request with a cycle-free model kept in a scoreboard class.
// Depends on dst_pkg and on the decoder RTL only.

import dst_pkg::*;

// Tracks the decoder's stream state, predicts each result request and checks it.
class dst_record_scoreboard;
  typedef struct {
    kind_e                        kind;
    logic signed [POS_WIDTH-1:0]  pos_x;
    logic signed [POS_WIDTH-1:0]  pos_y;
    logic [LAYER_WIDTH-1:0]       layer;
  } record_t;

  logic [LAYER_WIDTH-1:0] start_layer;
  logic [LAYER_WIDTH-1:0] layer;
  int unsigned            byte_count;
  int unsigned            rec_phase;
  logic [7:0]             rec_lo;
  logic [7:0]             rec_hi;
  bit                     header_bad;
  bit                     stroke_pending;
  longint                 acc_x;
  longint                 acc_y;
  mode_e                  mode;
  record_t                pending_records[$];
  int unsigned            failures;
  int unsigned            predicted;

  function new();
    start_layer = '0;
    failures    = 0;
    predicted   = 0;
    restart();
  endfunction

  // Stream state after reset or after the final byte of a file.
  function void restart();
    byte_count     = 0;
    rec_phase      = 0;
    rec_lo         = '0;
    rec_hi         = '0;
    header_bad     = 1'b0;
    acc_x          = 0;
    acc_y          = 0;
    layer          = start_layer;
    stroke_pending = 1'b1;
    mode           = MODE_HEADER;
  endfunction

  // The current layer follows the register only before the first byte of a file.
  function void set_start_layer(logic [LAYER_WIDTH-1:0] value);
    start_layer = value;
    if (byte_count == 0 && mode == MODE_HEADER) layer = value;
  endfunction

  static function int digit(bit plus, bit minus, int weight);
    return (plus ? weight : 0) - (minus ? weight : 0);
  endfunction

  function longint clamp(longint value);
    longint top;
    top = (longint'(1) << (POS_WIDTH - 1)) - 1;
    if (value > top) return top;
    if (value < -top - 1) return -top - 1;
    return value;
  endfunction

  function void push_expected(kind_e kind);
    record_t rec;
    rec.kind  = kind;
    rec.pos_x = acc_x[POS_WIDTH-1:0];
    rec.pos_y = acc_y[POS_WIDTH-1:0];
    rec.layer = layer;
    pending_records.push_back(rec);
    predicted++;
  endfunction

  // Moves the pen by the ternary digits of one record and classifies it by its flags.
  function kind_e decode(logic [7:0] u, logic [7:0] v, logic [7:0] w);
    int dx;
    int dy;
    dx = digit(u[0], u[1], 1) + digit(u[2], u[3], 9) + digit(v[0], v[1], 3)
       + digit(v[2], v[3], 27) + digit(w[2], w[3], 81);
    dy = digit(u[7], u[6], 1) + digit(u[5], u[4], 9) + digit(v[7], v[6], 3)
       + digit(v[5], v[4], 27) + digit(w[5], w[4], 81);
    acc_x = clamp(acc_x + dx);
    acc_y = clamp(acc_y + dy);
    if ((w & MASK_END) == MASK_END) begin
      mode = MODE_DONE;
      return (u == 8'h00 && v == 8'h00) ? KIND_END : KIND_BAD_END;
    end
    if ((w & MASK_COLOR) == MASK_COLOR) begin
      layer = layer + 1'b1;
      return KIND_COLOR;
    end
    if ((w & MASK_JUMP) == MASK_JUMP) begin
      stroke_pending = 1'b1;
      return KIND_JUMP;
    end
    if ((w & MASK_STITCH) == MASK_STITCH) begin
      if (stroke_pending) begin
        stroke_pending = 1'b0;
        return KIND_START;
      end
      return KIND_STITCH;
    end
    return KIND_UNKNOWN;
  endfunction

  // Called for every accepted byte request.
  function void note_byte(logic [7:0] data, bit is_last);
    bit produced;
    produced = 1'b0;
    case (mode)
      MODE_HEADER: begin
        if (byte_count < MAGIC_LEN && data != MAGIC[byte_count]) header_bad = 1'b1;
        byte_count++;
        if (byte_count >= HEADER_BYTES) mode = MODE_RECORDS;
      end
      MODE_RECORDS: begin
        if (byte_count < FIRST_REC_END) byte_count++;
        if (rec_phase == 0) begin
          rec_lo    = data;
          rec_phase = 1;
        end else if (rec_phase == 1) begin
          rec_hi    = data;
          rec_phase = 2;
        end else begin
          rec_phase = 0;
          if (header_bad) begin
            mode = MODE_DONE;
            push_expected(KIND_BAD_HEADER);
          end else begin
            push_expected(decode(rec_lo, rec_hi, data));
          end
          produced = 1'b1;
        end
      end
      default: ;
    endcase
    // A file that ends before its first record is complete reports itself as too short.
    if (is_last) begin
      if (!produced && byte_count < FIRST_REC_END) begin
        acc_x = 0;
        acc_y = 0;
        push_expected(KIND_TOO_SHORT);
      end
      restart();
    end
  endfunction

  // Called for every accepted result request.
  function void check_record(logic [3:0] kind, logic signed [POS_WIDTH-1:0] pos_x,
                             logic signed [POS_WIDTH-1:0] pos_y,
                             logic [LAYER_WIDTH-1:0] layer_v);
    record_t rec;
    if (pending_records.size() == 0) begin
      $error("unexpected result: kind %0d pos_x %0d pos_y %0d layer %0d",
             kind, pos_x, pos_y, layer_v);
      failures++;
      return;
    end
    rec = pending_records.pop_front();
    if (kind !== rec.kind) begin
      $error("kind: expected %0d, actual %0d", rec.kind, kind);
      failures++;
    end
    if (pos_x !== rec.pos_x) begin
      $error("pos_x: expected %0d, actual %0d", rec.pos_x, pos_x);
      failures++;
    end
    if (pos_y !== rec.pos_y) begin
      $error("pos_y: expected %0d, actual %0d", rec.pos_y, pos_y);
      failures++;
    end
    if (layer_v !== rec.layer) begin
      $error("layer: expected %0d, actual %0d", rec.layer, layer_v);
      failures++;
    end
  endfunction
endclass

module dst_stitch_stream_decoder_tb;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned SettleCycles  = 8;

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [LAYER_WIDTH-1:0]       cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [7:0]                   file_byte_i = '0;
  logic                         last_byte_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [3:0]                   kind_o;
  logic signed [POS_WIDTH-1:0]  pos_x_o;
  logic signed [POS_WIDTH-1:0]  pos_y_o;
  logic [LAYER_WIDTH-1:0]       layer_o;

  dst_record_scoreboard sb;
  logic [7:0]           file_bytes[$];
  bit                   steady_tail = 1'b0;
  int unsigned          tx_quiet    = 0;
  int unsigned          rx_quiet    = 0;
  int unsigned          stall_left  = 0;
  int unsigned          idle_cycles = 0;

  dst_stitch_stream_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .file_byte_i (file_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .layer_o     (layer_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: checks each taken result and stalls in random bursts, with calm stretches.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_record(kind_o, pos_x_o, pos_y_o, layer_o);
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (steady_tail) begin
      out_stall_i <= 1'b0;
    end else if (rx_quiet != 0) begin
      rx_quiet--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 39) == 0) begin
      rx_quiet = $urandom_range(50, 300);
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: ends the run when no request moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Sender gap before the next byte: random bursts, calm stretches, none at the tail.
  function automatic int unsigned next_gap();
    if (steady_tail) return 0;
    if (tx_quiet != 0) begin
      tx_quiet--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      tx_quiet = $urandom_range(50, 300);
      return 0;
    end
    if ($urandom_range(0, 6) == 0) return $urandom_range(1, 14);
    return 0;
  endfunction

  function automatic void push_record(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    file_bytes.push_back(b0);
    file_bytes.push_back(b1);
    file_bytes.push_back(b2);
  endfunction

  // Header with the magic in front and random filler; optionally one magic byte broken.
  function automatic void push_header(bit bad_magic);
    for (int unsigned i = 0; i < HEADER_BYTES; i++) begin
      file_bytes.push_back(i < MAGIC_LEN ? MAGIC[i] : 8'($urandom));
    end
    if (bad_magic) begin
      file_bytes[$urandom_range(0, MAGIC_LEN - 1)] ^= 8'($urandom_range(1, 255));
    end
  endfunction

  // Random record whose flag bits select the given class.
  function automatic void push_random_record(kind_e cls);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    b2 = 8'($urandom);
    case (cls)
      KIND_STITCH: begin
        b2[7]   = 1'b0;
        b2[1:0] = 2'b11;
      end
      KIND_JUMP: begin
        b2[7:6] = 2'b10;
        b2[1:0] = 2'b11;
      end
      KIND_COLOR: begin
        b2[7:6] = 2'b11;
        b2[5:4] = 2'($urandom_range(0, 2));
        b2[1:0] = 2'b11;
      end
      KIND_END: begin
        b0 = 8'h00;
        b1 = 8'h00;
        b2 = b2 | MASK_END;
      end
      KIND_BAD_END: begin
        b2 = b2 | MASK_END;
        if (b0 == 8'h00 && b1 == 8'h00) b1 = 8'h01;
      end
      default: b2[1:0] = 2'($urandom_range(0, 2));
    endcase
    push_record(b0, b1, b2);
  endfunction

  // Drives one byte request and holds it until the decoder takes it.
  task automatic send_byte(logic [7:0] data, bit is_last);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    file_byte_i <= data;
    last_byte_i <= is_last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(data, is_last);
  endtask

  // Stops sending and waits until every predicted result has been taken.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_start_layer(logic [LAYER_WIDTH-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_start_layer(value);
    cfg_we_i    <= 1'b0;
  endtask

  // Sends the built file, optionally writing the register while it is half sent.
  task automatic play_file(int unsigned cfg_at, logic [LAYER_WIDTH-1:0] cfg_value);
    for (int unsigned i = 0; i < file_bytes.size(); i++) begin
      if (cfg_at != 0 && i == cfg_at) load_start_layer(cfg_value);
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
  endtask

  // Sends a file of the given length that ends long before its first record.
  task automatic play_short_file(int unsigned len, bit bad_magic);
    file_bytes.delete();
    push_header(bad_magic);
    while (file_bytes.size() > len) void'(file_bytes.pop_back());
    play_file(0, '0);
  endtask

  initial begin
    int unsigned pick;

    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_start_layer(16'hFFFF);

    // Files that end before the first record is complete, one with a broken magic.
    for (int unsigned k = 1; k <= MAGIC_LEN; k++) begin
      play_short_file(k, k == MAGIC_LEN);
    end

    // Record classes and large moves both ways; the register changes mid-header,
    // so the layer of this file must stay put and the colour change wraps it to zero.
    // Bytes after the end record are ignored.
    file_bytes.delete();
    push_header(1'b0);
    push_record(8'h00, 8'h00, 8'h03);
    push_record(8'hA5, 8'hA5, 8'h27);
    push_record(8'h5A, 8'h5A, 8'h1B);
    push_record(8'hFF, 8'hFF, 8'h3F);
    push_record(8'h00, 8'h00, 8'h83);
    push_record(8'h12, 8'h34, 8'h03);
    push_record(8'h00, 8'h00, 8'hC3);
    push_record(8'h01, 8'h02, 8'h00);
    push_record(8'h00, 8'h00, 8'hFC);
    repeat (8) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) push_random_record(KIND_STITCH);
      else if (pick < 70) push_random_record(KIND_JUMP);
      else if (pick < 80) push_random_record(KIND_COLOR);
      else push_random_record(KIND_UNKNOWN);
    end
    push_record(8'h00, 8'h00, 8'hF3);
    push_record(8'h4C, 8'h41, 8'h3A);
    file_bytes.push_back(8'hFF);
    play_file(100, 16'h1234);

    // The next file must start from the new register value.
    play_short_file(1, 1'b0);
    load_start_layer(16'($urandom));

    // Final stretch without idling: short files back to back, one result per file.
    steady_tail = 1'b1;
    repeat (8) begin
      play_short_file($urandom_range(1, 6), 1'($urandom_range(0, 1)));
    end

    settle();
    if (sb.failures == 0 && sb.pending_records.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
design/dst_pkg.sv
design/dst_rec_dec.sv
design/dst_stitch_stream_decoder.sv
tb/dst_stitch_stream_decoder_tb.sv
